// ----- hdl/wdq_pkg.sv -----
// Shared types and constants of the word deque ring buffer.
// Holds the payload structs, action codes and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package wdq_pkg;

    localparam int DATA_W = 16;
    localparam int CNT_W  = 7;
    localparam int LVL_W  = 11;
    localparam int ACT_W  = 3;

    localparam int DEPTH_DEF     = 1024;
    localparam int MAX_BURST_DEF = 64;

    localparam logic [LVL_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [ACT_W-1:0] ACT_PUSH_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_TAIL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ_HEAD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_TAIL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DROP_HEAD = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DROP_TAIL = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] data_word;
        logic [CNT_W-1:0]  count;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] out_word;
        logic              word_valid;
        logic              last;
        logic [CNT_W-1:0]  moved;
        logic [LVL_W-1:0]  fill_level;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // capture the accepted request
        logic exec;    // apply the request to pointers and level
        logic rd_en;   // issue one memory read
        logic load;    // move the read word into the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic burst;       // request is a read that takes at least one word
        logic out_free;    // output register can take a result this cycle
        logic final_word;  // the pending read word is the last one
    } dp_status_t;

endpackage

// ----- hdl/word_deque_ring_buffer.sv -----
// Top level of the word deque ring buffer: controller plus datapath.
// Depends on wdq_pkg, wdq_ctrl, wdq_datapath (and wdq_ram below it).
`timescale 1ns / 1ps

// Channel    Direction  Handshake            Payload
// in         sink       in_valid / in_stall   wdq_pkg::in_item_t (action, data_word, count)
// out        source     out_valid / out_stall wdq_pkg::out_item_t (one result per word read, or per request)
// cfg        sink       cfg_wr_en            cfg_wr_data = capacity
//
// One request is handled at a time. A push, drop, clear or empty read is
// accepted, then applied, and its result is loaded into the output register
// once that register is free. A read of n words is accepted and applied, then
// each word takes a memory read step and then a step that moves the registered
// data into the output register. Reset empties the deque and sets the capacity
// to its default; no memory clearing pass is run. A stalled output holds the
// result and pauses the read sequence; a capacity write empties the deque.

module word_deque_ring_buffer #(
    parameter int DEPTH     = wdq_pkg::DEPTH_DEF,
    parameter int MAX_BURST = wdq_pkg::MAX_BURST_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  wdq_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output wdq_pkg::out_item_t        out_item,
    input  logic                      cfg_wr_en,
    input  logic [wdq_pkg::LVL_W-1:0] cfg_wr_data
);

    wdq_pkg::ctrl_cmd_t  cmd;
    wdq_pkg::dp_status_t status;

    // Sequence each request: accept, apply, then read words one by one
    wdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold pointers, level, capacity, word memory and the output register
    wdq_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

// ----- hdl/wdq_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module wdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/wdq_ctrl.sv -----
// Sequencing state machine of the word deque ring buffer.
// Depends on wdq_pkg for the command and status structs.
`timescale 1ns / 1ps

module wdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wdq_pkg::dp_status_t status,
    output wdq_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // a burst needs no output slot yet; single results do
                cmd.exec = status.burst | status.out_free;
                if (status.burst)
                begin
                    state_next = S_READ;
                end
                else if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load = status.out_free;
                if (status.out_free)
                begin
                    state_next = status.final_word ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- hdl/wdq_datapath.sv -----
// Pointers, fill level, word memory and output register of the deque.
// Depends on wdq_pkg and wdq_ram.
`timescale 1ns / 1ps

module wdq_datapath #(
    parameter int DEPTH     = wdq_pkg::DEPTH_DEF,
    parameter int MAX_BURST = wdq_pkg::MAX_BURST_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wdq_pkg::in_item_t             in_item,
    input  logic                          cfg_wr_en,
    input  logic [wdq_pkg::LVL_W-1:0]     cfg_wr_data,
    input  wdq_pkg::ctrl_cmd_t            cmd,
    output wdq_pkg::dp_status_t           status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wdq_pkg::out_item_t            out_item
);

    localparam int LW = wdq_pkg::LVL_W;
    localparam int CW = wdq_pkg::CNT_W;
    localparam int DW = wdq_pkg::DATA_W;
    localparam int AW = $clog2(DEPTH);
    // Pointers never reach the capacity, which fits in LW bits
    localparam int PW = (AW < LW) ? AW : LW;
    localparam int SW = LW + 1;

    function automatic logic [LW-1:0] eff_cap(input logic [LW-1:0] v);
        logic [LW-1:0] c;
        c = v;
        if (v == '0)
        begin
            c = LW'(1);
        end
        else if (32'(v) > DEPTH)
        begin
            c = LW'(DEPTH);
        end
        return c;
    endfunction

    wdq_pkg::in_item_t  item_reg;
    wdq_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;

    logic [LW-1:0] cap_reg;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [LW-1:0] level_reg, level_next;
    logic [PW-1:0] rd_addr_reg;
    logic [CW-1:0] remain_reg;
    logic [CW-1:0] moved_reg;

    logic [CW-1:0] cnt_sat, n, moved;
    logic [SW-1:0] head_s, tail_s, cap_s, n_s, head_add_s, tail_inc_s, rd_inc_s;
    logic [PW-1:0] head_dec, tail_inc, head_add, tail_sub, start, rd_addr_inc;
    logic          full, burst, out_free, load_out;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [DW-1:0] mem_rdata;

    // Saturated count and words actually available
    always_comb
    begin
        cnt_sat = (item_reg.count > CW'(MAX_BURST)) ? CW'(MAX_BURST) : item_reg.count;
        n       = (SW'(cnt_sat) < SW'(level_reg)) ? cnt_sat : CW'(level_reg);
    end

    // Wrapped pointer arithmetic; every pointer stays below cap_reg
    always_comb
    begin
        head_s      = SW'(head_reg);
        tail_s      = SW'(tail_reg);
        cap_s       = SW'(cap_reg);
        n_s         = SW'(n);
        head_dec    = (head_reg == '0) ? PW'(cap_s - SW'(1)) : head_reg - PW'(1);
        tail_inc_s  = tail_s + SW'(1);
        tail_inc    = (tail_inc_s == cap_s) ? '0 : PW'(tail_inc_s);
        head_add_s  = head_s + n_s;
        head_add    = (head_add_s >= cap_s) ? PW'(head_add_s - cap_s) : PW'(head_add_s);
        tail_sub    = (tail_s >= n_s) ? PW'(tail_s - n_s) : PW'(tail_s + cap_s - n_s);
        rd_inc_s    = SW'(rd_addr_reg) + SW'(1);
        rd_addr_inc = (rd_inc_s == cap_s) ? '0 : PW'(rd_inc_s);
        full        = (level_reg >= cap_reg);
        burst       = ((item_reg.action == wdq_pkg::ACT_READ_HEAD) ||
                       (item_reg.action == wdq_pkg::ACT_READ_TAIL)) && (n != '0);
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_dec;
        moved      = '0;
        start      = head_reg;
        unique case (item_reg.action)
            wdq_pkg::ACT_PUSH_HEAD:
            begin
                if (!full)
                begin
                    head_next  = head_dec;
                    mem_we     = 1'b1;
                    level_next = level_reg + LW'(1);
                    moved      = CW'(1);
                end
            end
            wdq_pkg::ACT_PUSH_TAIL:
            begin
                if (!full)
                begin
                    tail_next  = tail_inc;
                    mem_we     = 1'b1;
                    mem_waddr  = tail_reg;
                    level_next = level_reg + LW'(1);
                    moved      = CW'(1);
                end
            end
            wdq_pkg::ACT_READ_HEAD, wdq_pkg::ACT_DROP_HEAD:
            begin
                head_next  = head_add;
                level_next = level_reg - LW'(n);
                moved      = n;
            end
            wdq_pkg::ACT_READ_TAIL, wdq_pkg::ACT_DROP_TAIL:
            begin
                tail_next  = tail_sub;
                start      = tail_sub;
                level_next = level_reg - LW'(n);
                moved      = n;
            end
            wdq_pkg::ACT_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                level_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = cmd.load || (cmd.exec && !burst);

    assign status.burst      = burst;
    assign status.out_free   = out_free;
    assign status.final_word = (remain_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= eff_cap(wdq_pkg::CAP_RESET);
            head_reg   <= '0;
            tail_reg   <= '0;
            level_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg   <= eff_cap(cfg_wr_data);
                head_reg  <= '0;
                tail_reg  <= '0;
                level_reg <= '0;
            end
            else if (cmd.exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                level_reg <= level_next;
            end
            if (cmd.exec && burst)
            begin
                remain_reg <= n;
            end
            else if (cmd.load)
            begin
                remain_reg <= remain_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_item;
        end
        if (cmd.exec && burst)
        begin
            rd_addr_reg <= start;
            moved_reg   <= n;
        end
        else if (cmd.load)
        begin
            rd_addr_reg <= rd_addr_inc;
        end
        if (cmd.load)
        begin
            out_item_reg.out_word   <= mem_rdata;
            out_item_reg.word_valid <= 1'b1;
            out_item_reg.last       <= (remain_reg == CW'(1));
            out_item_reg.moved      <= moved_reg;
            out_item_reg.fill_level <= level_reg;
        end
        else if (cmd.exec && !burst)
        begin
            out_item_reg.out_word   <= '0;
            out_item_reg.word_valid <= 1'b0;
            out_item_reg.last       <= 1'b1;
            out_item_reg.moved      <= moved;
            out_item_reg.fill_level <= level_next;
        end
    end

    wdq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.exec && mem_we),
        .waddr (AW'(mem_waddr)),
        .wdata (item_reg.data_word),
        .re    (cmd.rd_en),
        .raddr (AW'(rd_addr_reg)),
        .rdata (mem_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
